// ===== sv/particle_wall_bounce_phase_histogram_top_defines.svh =====
// Assertion macros for the phase histogram RTL
`ifndef PARTICLE_WALL_BOUNCE_PHASE_HISTOGRAM_TOP_DEFINES_SVH
`define PARTICLE_WALL_BOUNCE_PHASE_HISTOGRAM_TOP_DEFINES_SVH

// Same-cycle implication, held off during reset
`define PWB_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("pwb check failed");

// Next-cycle implication, held off during reset
`define PWB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("pwb check failed");

`endif

// ===== sv/pwb_pkg.sv =====
// Types and constants of the particle wall bounce phase histogram
`default_nettype none
package pwb_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_WALL_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WALL_RIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WALL_TOP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WALL_BOTTOM = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_BW      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MOM_BW      = 3'd5;

    // Register reset values
    localparam logic signed [15:0] RST_WALL_LEFT   = -16'sd7680;
    localparam logic signed [15:0] RST_WALL_RIGHT  = 16'sd7680;
    localparam logic signed [15:0] RST_WALL_TOP    = 16'sd7680;
    localparam logic signed [15:0] RST_WALL_BOTTOM = -16'sd7680;
    localparam logic [14:0]        RST_POS_BW      = 15'd1396;
    localparam logic [14:0]        RST_MOM_BW      = 15'd3072;

    // Item action codes
    localparam logic ACT_MOVE  = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    // Number of reflection passes per move
    localparam int REF_PASSES = 2;

    // Divider operand widths
    localparam int DIVIDEND_W = 24;
    localparam int BW_W       = 15;

    typedef struct packed {
        logic signed [15:0] wall_left;
        logic signed [15:0] wall_right;
        logic signed [15:0] wall_top;
        logic signed [15:0] wall_bottom;
        logic [14:0]        pos_bw;
        logic [14:0]        mom_bw;
    } t_cfg;

    // Queue entry from front to back
    typedef struct packed {
        logic               action;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [23:0] mx;
        logic signed [23:0] my;
    } t_qent;

    typedef struct packed {
        logic init_done;
    } t_back_stat;

endpackage
`default_nettype wire

// ===== sv/pwb_channels.sv =====
// Channel interfaces: move/clear items, result items and register writes
`default_nettype none
interface pwb_item_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic [7:0]         mass;
    logic [15:0]        time_step;
    modport source(output valid, action, pos_x, pos_y, vel_x, vel_y, mass, time_step,
                   input ready);
    modport sink(input valid, action, pos_x, pos_y, vel_x, vel_y, mass, time_step,
                 output ready);
endinterface

interface pwb_result_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] new_pos_x;
    logic signed [15:0] new_pos_y;
    logic signed [15:0] new_vel_x;
    logic signed [15:0] new_vel_y;
    logic signed [23:0] mom_x;
    logic signed [23:0] mom_y;
    logic [3:0]         pos_cell_x;
    logic [3:0]         pos_cell_y;
    logic [2:0]         mom_cell_x;
    logic [2:0]         mom_cell_y;
    logic [7:0]         cell_count;
    modport source(output valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y, mom_x, mom_y,
                   pos_cell_x, pos_cell_y, mom_cell_x, mom_cell_y, cell_count,
                   input ready);
    modport sink(input valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y, mom_x, mom_y,
                 pos_cell_x, pos_cell_y, mom_cell_x, mom_cell_y, cell_count,
                 output ready);
endinterface

interface pwb_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [pwb_pkg::CFG_IDX_W-1:0]     idx;
    logic [15:0]                       data;
    modport source(output valid, idx, data, input ready);
    modport sink(input valid, idx, data, output ready);
endinterface
`default_nettype wire

// ===== sv/pwb_front.sv =====
// Front: accepts items, advances the particle, reflects it and forms momentum
`default_nettype none
module pwb_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    pwb_item_if.sink            i_item,
    input  pwb_pkg::t_cfg       i_cfg,
    input  pwb_pkg::t_back_stat i_stat,
    input  logic                i_q_full,
    output logic                o_q_push,
    output pwb_pkg::t_qent      o_q_data
);
    typedef enum logic [2:0] {F_IDLE, F_MUL, F_ADV, F_REF, F_MOM, F_PUSH} t_fstate;

    t_fstate            r_state;
    logic               r_act;
    logic signed [25:0] r_px, r_py;
    logic signed [15:0] r_vx, r_vy;
    logic [7:0]         r_m;
    logic [15:0]        r_dt;
    logic signed [32:0] r_prx, r_pry;
    logic               r_pass;
    logic signed [15:0] r_sx, r_sy;
    logic signed [23:0] r_mx, r_my;

    logic               w_accept;
    logic signed [37:0] w_ex, w_ey, w_dx30, w_dy30;
    logic signed [25:0] w_dx, w_dy;
    logic signed [25:0] w_wl, w_wr, w_wt, w_wb;
    logic signed [25:0] n_px, n_py;
    logic signed [15:0] n_vx, n_vy;
    logic signed [24:0] w_mx, w_my;

    function automatic logic signed [15:0] sat16(input logic signed [25:0] v);
        if (v > 26'sd32767) begin
            return 16'sd32767;
        end else if (v < -26'sd32768) begin
            return -16'sd32768;
        end
        return v[15:0];
    endfunction

    function automatic logic signed [15:0] neg16(input logic signed [15:0] v);
        if (v == -16'sd32768) begin
            return 16'sd32767;
        end
        return -v;
    endfunction

    assign i_item.ready = (r_state == F_IDLE) && i_stat.init_done;
    assign w_accept     = i_item.valid && i_item.ready;

    // Scale the product by 30 and floor to Q8.8
    assign w_ex   = {{5{r_prx[32]}}, r_prx};
    assign w_ey   = {{5{r_pry[32]}}, r_pry};
    assign w_dx30 = (w_ex <<< 5) - (w_ex <<< 1);
    assign w_dy30 = (w_ey <<< 5) - (w_ey <<< 1);
    assign w_dx   = {{4{w_dx30[37]}}, w_dx30[37:16]};
    assign w_dy   = {{4{w_dy30[37]}}, w_dy30[37:16]};

    assign w_wl = {{10{i_cfg.wall_left[15]}}, i_cfg.wall_left};
    assign w_wr = {{10{i_cfg.wall_right[15]}}, i_cfg.wall_right};
    assign w_wt = {{10{i_cfg.wall_top[15]}}, i_cfg.wall_top};
    assign w_wb = {{10{i_cfg.wall_bottom[15]}}, i_cfg.wall_bottom};

    // One reflection pass: first wall hit in order left, right, top, bottom
    always_comb begin
        n_px = r_px;
        n_py = r_py;
        n_vx = r_vx;
        n_vy = r_vy;
        if (r_px < w_wl) begin
            n_px = (w_wl <<< 1) - r_px;
            n_vx = neg16(r_vx);
        end else if (r_px > w_wr) begin
            n_px = (w_wr <<< 1) - r_px;
            n_vx = neg16(r_vx);
        end else if (r_py > w_wt) begin
            n_py = (w_wt <<< 1) - r_py;
            n_vy = neg16(r_vy);
        end else if (r_py < w_wb) begin
            n_py = (w_wb <<< 1) - r_py;
            n_vy = neg16(r_vy);
        end
    end

    assign w_mx = $signed({1'b0, r_m}) * r_vx;
    assign w_my = $signed({1'b0, r_m}) * r_vy;

    assign o_q_push = (r_state == F_PUSH) && !i_q_full;
    always_comb begin
        o_q_data.action = r_act;
        o_q_data.px     = r_sx;
        o_q_data.py     = r_sy;
        o_q_data.vx     = r_vx;
        o_q_data.vy     = r_vy;
        o_q_data.mx     = r_mx;
        o_q_data.my     = r_my;
    end

    // Sequence a move item through multiply, advance, reflect and momentum; a clear item goes straight to the push
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_pass  <= 1'b0;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (w_accept) begin
                        r_act  <= i_item.action;
                        r_px   <= {{10{i_item.pos_x[15]}}, i_item.pos_x};
                        r_py   <= {{10{i_item.pos_y[15]}}, i_item.pos_y};
                        r_vx   <= i_item.vel_x;
                        r_vy   <= i_item.vel_y;
                        r_m    <= i_item.mass;
                        r_dt   <= i_item.time_step;
                        r_pass <= 1'b0;
                        r_state <= (i_item.action == pwb_pkg::ACT_CLEAR) ? F_PUSH : F_MUL;
                    end
                end
                F_MUL: begin
                    r_prx   <= r_vx * $signed({1'b0, r_dt});
                    r_pry   <= r_vy * $signed({1'b0, r_dt});
                    r_state <= F_ADV;
                end
                F_ADV: begin
                    r_px    <= r_px + w_dx;
                    r_py    <= r_py + w_dy;
                    r_state <= F_REF;
                end
                F_REF: begin
                    r_px   <= n_px;
                    r_py   <= n_py;
                    r_vx   <= n_vx;
                    r_vy   <= n_vy;
                    r_pass <= 1'b1;
                    if (r_pass == 1'(pwb_pkg::REF_PASSES - 1)) begin
                        r_state <= F_MOM;
                    end
                end
                F_MOM: begin
                    r_sx    <= sat16(r_px);
                    r_sy    <= sat16(r_py);
                    r_mx    <= w_mx[23:0];
                    r_my    <= w_my[23:0];
                    r_state <= F_PUSH;
                end
                F_PUSH: begin
                    if (!i_q_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== sv/pwb_queue.sv =====
// Two-entry queue between the front and the back
`default_nettype none
module pwb_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pwb_pkg::t_qent i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output pwb_pkg::t_qent o_data
);
    pwb_pkg::t_qent r_mem [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    // Store pushed items
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end
endmodule
`default_nettype wire

// ===== sv/pwb_div.sv =====
// Restoring divider, one quotient bit per cycle, with an overflow flag
`default_nettype none
module pwb_div #(
    parameter int QB = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [pwb_pkg::DIVIDEND_W-1:0] i_dividend,
    input  logic [pwb_pkg::BW_W-1:0]       i_divisor,
    output logic                           o_busy,
    output logic [QB-1:0]                  o_quot,
    output logic                           o_ovf
);
    localparam int SW  = pwb_pkg::DIVIDEND_W;
    localparam int WW  = pwb_pkg::BW_W;
    localparam int DW  = WW + QB - 1;
    localparam int CW  = ((SW > WW + QB) ? SW : WW + QB) + 1;
    localparam int CNW = $clog2(QB + 1);

    logic           r_busy;
    logic [CNW-1:0] r_cnt;
    logic [SW-1:0]  r_rem;
    logic [DW-1:0]  r_dsh;
    logic [QB-1:0]  r_q;
    logic           r_ovf;
    logic           w_ge;
    logic           w_big;

    assign w_big  = CW'(i_dividend) >= (CW'(i_divisor) << QB);
    assign w_ge   = CW'(r_rem) >= CW'(r_dsh);
    assign o_busy = r_busy;
    assign o_quot = r_q;
    assign o_ovf  = r_ovf;

    // Load operands, then produce one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNW'(QB);
            r_rem  <= i_dividend;
            r_dsh  <= DW'(i_divisor) << (QB - 1);
            r_q    <= '0;
            r_ovf  <= w_big;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= r_rem - SW'(r_dsh);
            end
            r_q   <= QB'({r_q, w_ge});
            r_dsh <= r_dsh >> 1;
            r_cnt <= r_cnt - CNW'(1);
            if (r_cnt == CNW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

// ===== sv/pwb_back.sv =====
// Back: bins a particle, updates the histogram and clears it on request
`default_nettype none
`include "particle_wall_bounce_phase_histogram_top_defines.svh"
module pwb_back #(
    parameter int POS_CELLS   = 11,
    parameter int MOM_CELLS   = 5,
    parameter int COUNT_WIDTH = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pwb_pkg::t_cfg       i_cfg,
    input  logic                i_q_valid,
    input  pwb_pkg::t_qent      i_q_data,
    output logic                o_q_pop,
    output pwb_pkg::t_back_stat o_stat,
    pwb_result_if.source        o_result
);
    localparam int QBP   = $clog2(POS_CELLS);
    localparam int QBM   = $clog2(MOM_CELLS);
    localparam int DEPTH = POS_CELLS * POS_CELLS * MOM_CELLS * MOM_CELLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = COUNT_WIDTH;
    localparam int SW    = pwb_pkg::DIVIDEND_W;

    typedef enum logic [2:0] {B_INIT, B_IDLE, B_START, B_DIV, B_IDX, B_RD, B_WR, B_CLR}
        t_bstate;

    t_bstate         r_state;
    pwb_pkg::t_qent  r_ent;
    logic [AW-1:0]   r_addr;
    logic [CW-1:0]   r_rdata;
    logic [CW-1:0]   r_hist [DEPTH];
    logic [QBP-1:0]  r_rx, r_ry;
    logic [QBM-1:0]  r_qx, r_qy;
    logic            r_ov;

    logic [SW-1:0]   w_sx, w_sy, w_smx, w_smy;
    logic [14:0]     w_pbw, w_mbw;
    logic            w_bp_x, w_bp_y, w_bm_x, w_bm_y;
    logic [QBP-1:0]  w_qp_x, w_qp_y;
    logic [QBM-1:0]  w_qm_x, w_qm_y;
    logic            w_op_x, w_op_y, w_om_x, w_om_y;
    logic            w_start, w_pop, w_out_free, w_ld_out, w_wr_en, w_div_busy;
    logic [CW-1:0]   w_inc, w_wr_data;
    logic [CW+8:0]   w_cnt_ext;
    logic [AW-1:0]   w_idx;
    logic [QBP+3:0]  w_rx_e, w_ry_e;
    logic [QBM+2:0]  w_qx_e, w_qy_e;

    // Offset by the wall magnitude; a sum at or below zero bins to cell zero
    function automatic logic [SW-1:0] cell_dividend(input logic signed [23:0] v,
                                                   input logic signed [15:0] wall);
        logic signed [16:0] w17;
        logic signed [16:0] m17;
        logic signed [25:0] s;
        w17 = {wall[15], wall};
        m17 = w17[16] ? -w17 : w17;
        s   = {{2{v[23]}}, v} + {9'd0, m17};
        if (s <= 26'sd0) begin
            return '0;
        end
        return s[SW-1:0];
    endfunction

    // Clamp a quotient to the last cell of its axis
    function automatic logic [QBP-1:0] clamp_p(input logic ovf, input logic [QBP-1:0] q);
        if (ovf || (32'(q) >= POS_CELLS)) begin
            return QBP'(POS_CELLS - 1);
        end
        return q;
    endfunction

    function automatic logic [QBM-1:0] clamp_m(input logic ovf, input logic [QBM-1:0] q);
        if (ovf || (32'(q) >= MOM_CELLS)) begin
            return QBM'(MOM_CELLS - 1);
        end
        return q;
    endfunction

    assign w_sx  = cell_dividend({{8{r_ent.px[15]}}, r_ent.px}, i_cfg.wall_left);
    assign w_sy  = cell_dividend({{8{r_ent.py[15]}}, r_ent.py}, i_cfg.wall_bottom);
    assign w_smx = cell_dividend(r_ent.mx, i_cfg.wall_left);
    assign w_smy = cell_dividend(r_ent.my, i_cfg.wall_bottom);
    assign w_pbw = (i_cfg.pos_bw == 15'd0) ? 15'd1 : i_cfg.pos_bw;
    assign w_mbw = (i_cfg.mom_bw == 15'd0) ? 15'd1 : i_cfg.mom_bw;
    assign w_start = (r_state == B_START);

    pwb_div #(.QB(QBP)) u_div_px (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start), .i_dividend(w_sx),
        .i_divisor(w_pbw), .o_busy(w_bp_x), .o_quot(w_qp_x), .o_ovf(w_op_x)
    );
    pwb_div #(.QB(QBP)) u_div_py (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start), .i_dividend(w_sy),
        .i_divisor(w_pbw), .o_busy(w_bp_y), .o_quot(w_qp_y), .o_ovf(w_op_y)
    );
    pwb_div #(.QB(QBM)) u_div_mx (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start), .i_dividend(w_smx),
        .i_divisor(w_mbw), .o_busy(w_bm_x), .o_quot(w_qm_x), .o_ovf(w_om_x)
    );
    pwb_div #(.QB(QBM)) u_div_my (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start), .i_dividend(w_smy),
        .i_divisor(w_mbw), .o_busy(w_bm_y), .o_quot(w_qm_y), .o_ovf(w_om_y)
    );

    assign w_div_busy = w_bp_x || w_bp_y || w_bm_x || w_bm_y;

    // Flatten the four cell indexes into a histogram address
    assign w_idx = AW'(((32'(r_rx) * POS_CELLS + 32'(r_ry)) * MOM_CELLS + 32'(r_qx))
                       * MOM_CELLS + 32'(r_qy));

    // Saturating increment of the count read back
    assign w_inc      = (r_rdata == {CW{1'b1}}) ? r_rdata : r_rdata + CW'(1);
    assign w_cnt_ext  = (CW + 9)'(w_inc);
    assign w_out_free = !r_ov || o_result.ready;
    assign w_ld_out   = (r_state == B_WR) && w_out_free;
    assign w_pop      = (r_state == B_IDLE) && i_q_valid;
    assign o_q_pop    = w_pop;
    assign w_wr_en    = (r_state == B_INIT) || (r_state == B_CLR) || w_ld_out;
    assign w_wr_data  = w_ld_out ? w_inc : '0;
    assign o_stat.init_done = (r_state != B_INIT);

    assign w_rx_e = (QBP + 4)'(r_rx);
    assign w_ry_e = (QBP + 4)'(r_ry);
    assign w_qx_e = (QBM + 3)'(r_qx);
    assign w_qy_e = (QBM + 3)'(r_qy);

    assign o_result.valid = r_ov;

    // Histogram storage with registered read
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_hist[r_addr] <= w_wr_data;
        end
        r_rdata <= r_hist[r_addr];
    end

    // Sequence clearing sweeps and the bin/read/update of each move
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_INIT;
            r_addr  <= '0;
            r_ov    <= 1'b0;
        end else begin
            // Drop the result once taken, unless a new one loads in its place
            if (r_ov && o_result.ready && !w_ld_out) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                B_INIT, B_CLR: begin
                    if (r_addr == AW'(DEPTH - 1)) begin
                        r_addr  <= '0;
                        r_state <= B_IDLE;
                    end else begin
                        r_addr <= r_addr + AW'(1);
                    end
                end
                B_IDLE: begin
                    if (w_pop) begin
                        r_ent  <= i_q_data;
                        r_addr <= '0;
                        r_state <= (i_q_data.action == pwb_pkg::ACT_CLEAR) ? B_CLR : B_START;
                    end
                end
                B_START: r_state <= B_DIV;
                B_DIV: begin
                    if (!w_div_busy) begin
                        r_rx    <= clamp_p(w_op_x, w_qp_x);
                        r_ry    <= clamp_p(w_op_y, w_qp_y);
                        r_qx    <= clamp_m(w_om_x, w_qm_x);
                        r_qy    <= clamp_m(w_om_y, w_qm_y);
                        r_state <= B_IDX;
                    end
                end
                B_IDX: begin
                    r_addr  <= w_idx;
                    r_state <= B_RD;
                end
                B_RD: r_state <= B_WR;
                B_WR: begin
                    if (w_out_free) begin
                        r_ov                <= 1'b1;
                        o_result.new_pos_x  <= r_ent.px;
                        o_result.new_pos_y  <= r_ent.py;
                        o_result.new_vel_x  <= r_ent.vx;
                        o_result.new_vel_y  <= r_ent.vy;
                        o_result.mom_x      <= r_ent.mx;
                        o_result.mom_y      <= r_ent.my;
                        o_result.pos_cell_x <= w_rx_e[3:0];
                        o_result.pos_cell_y <= w_ry_e[3:0];
                        o_result.mom_cell_x <= w_qx_e[2:0];
                        o_result.mom_cell_y <= w_qy_e[2:0];
                        o_result.cell_count <= (w_cnt_ext > (CW + 9)'(255)) ? 8'hFF
                                                                            : w_cnt_ext[7:0];
                        r_state             <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    `PWB_ASSERT_NOW(a_pop_when_idle, i_clk, i_rst_n, w_pop, r_state == B_IDLE)
    `PWB_ASSERT_NEXT(a_div_started, i_clk, i_rst_n, r_state == B_START, w_div_busy)
    `PWB_ASSERT_NOW(a_no_result_overrun, i_clk, i_rst_n, w_ld_out, !r_ov || o_result.ready)
    `PWB_ASSERT_NOW(a_count_grows, i_clk, i_rst_n, w_ld_out, w_wr_data >= r_rdata)
endmodule
`default_nettype wire

// ===== sv/particle_wall_bounce_phase_histogram_top.sv =====
// Top level of the particle wall bounce phase histogram
//
//  channel   | role   | handshake    | carries
//  i_item    | in     | valid/ready  | action, position, velocity, mass, time step
//  o_result  | out    | valid/ready  | new state, momentum, cells, cell count
//  i_cfg     | in     | valid/ready  | register index, write data
//
// A move item passes through the front in order (accept, multiply, advance, two
// reflection passes, momentum, hand-off, which waits while the queue is full) and
// through the back (take, start, the bit-serial cell dividers, index, read, write);
// the two overlap through a two-entry queue.
// After reset the back sweeps all POS_CELLS^2 * MOM_CELLS^2 histogram entries
// (3025 by default) and takes no item meanwhile; a clear item repeats the sweep.
// A stalled result holds in the output register while the next item is binned.
`default_nettype none
module particle_wall_bounce_phase_histogram_top #(
    parameter int POS_CELLS   = 11,
    parameter int MOM_CELLS   = 5,
    parameter int COUNT_WIDTH = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pwb_item_if.sink      i_item,
    pwb_result_if.source  o_result,
    pwb_cfg_if.sink       i_cfg
);
    pwb_pkg::t_cfg       r_cfg;
    pwb_pkg::t_qent      w_push_data, w_pop_data;
    pwb_pkg::t_back_stat w_stat;
    logic                w_push, w_full, w_pop, w_qvalid;

    assign i_cfg.ready = 1'b1;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wall_left   <= pwb_pkg::RST_WALL_LEFT;
            r_cfg.wall_right  <= pwb_pkg::RST_WALL_RIGHT;
            r_cfg.wall_top    <= pwb_pkg::RST_WALL_TOP;
            r_cfg.wall_bottom <= pwb_pkg::RST_WALL_BOTTOM;
            r_cfg.pos_bw      <= pwb_pkg::RST_POS_BW;
            r_cfg.mom_bw      <= pwb_pkg::RST_MOM_BW;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.idx)
                pwb_pkg::CFG_WALL_LEFT:   r_cfg.wall_left   <= i_cfg.data;
                pwb_pkg::CFG_WALL_RIGHT:  r_cfg.wall_right  <= i_cfg.data;
                pwb_pkg::CFG_WALL_TOP:    r_cfg.wall_top    <= i_cfg.data;
                pwb_pkg::CFG_WALL_BOTTOM: r_cfg.wall_bottom <= i_cfg.data;
                pwb_pkg::CFG_POS_BW:      r_cfg.pos_bw      <= i_cfg.data[14:0];
                pwb_pkg::CFG_MOM_BW:      r_cfg.mom_bw      <= i_cfg.data[14:0];
                default: ;
            endcase
        end
    end

    pwb_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(i_item), .i_cfg(r_cfg),
        .i_stat(w_stat), .i_q_full(w_full), .o_q_push(w_push), .o_q_data(w_push_data)
    );

    pwb_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_push), .i_data(w_push_data),
        .o_full(w_full), .i_pop(w_pop), .o_valid(w_qvalid), .o_data(w_pop_data)
    );

    pwb_back #(
        .POS_CELLS(POS_CELLS), .MOM_CELLS(MOM_CELLS), .COUNT_WIDTH(COUNT_WIDTH)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg), .i_q_valid(w_qvalid),
        .i_q_data(w_pop_data), .o_q_pop(w_pop), .o_stat(w_stat), .o_result(o_result)
    );
endmodule
`default_nettype wire

// ===== sim/tb_particle_wall_bounce_phase_histogram_top.sv =====
// Testbench for the particle wall bounce phase histogram: random and directed moves, clears, wall setups
`default_nettype none
module tb_particle_wall_bounce_phase_histogram_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POS_N = 11;
    localparam int MOM_N = 5;
    localparam int HIST_N = POS_N * POS_N * MOM_N * MOM_N;
    localparam int SETTLE_CYCLES = 3200;

    typedef struct packed {
        logic               action;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic [7:0]         mass;
        logic [15:0]        time_step;
    } t_particle;

    typedef struct packed {
        logic signed [15:0] new_pos_x;
        logic signed [15:0] new_pos_y;
        logic signed [15:0] new_vel_x;
        logic signed [15:0] new_vel_y;
        logic signed [23:0] mom_x;
        logic signed [23:0] mom_y;
        logic [3:0]         pos_cell_x;
        logic [3:0]         pos_cell_y;
        logic [2:0]         mom_cell_x;
        logic [2:0]         mom_cell_y;
        logic [7:0]         cell_count;
    } t_bounce;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    pwb_item_if   item_ch();
    pwb_result_if res_ch();
    pwb_cfg_if    cfg_ch();

    particle_wall_bounce_phase_histogram_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_item(item_ch.sink), .o_result(res_ch.source), .i_cfg(cfg_ch.sink)
    );

    always #1 i_clk = ~i_clk;

    // Predictor state
    pwb_pkg::t_cfg wall_cfg;
    logic [7:0]  hist_counts [HIST_N];
    t_particle   pending_particles[$];
    t_bounce     expected_bounces[$];
    int          fail_count = 0;
    int          moves_checked = 0;
    int          clears_sent = 0;
    bit          quiet_tail = 1'b0;
    bit          pending_cfg = 1'b0;
    logic [2:0]  pending_idx;
    logic [15:0] pending_data;

    function automatic longint floor_shift16(longint v);
        if (v >= 0) return v / 65536;
        return -((-v + 65535) / 65536);
    endfunction

    function automatic longint clamp16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic int grid_cell(longint value, longint wall, longint width, int cells);
        longint s;
        longint q;
        s = value + ((wall < 0) ? -wall : wall);
        if (s <= 0) return 0;
        if (width == 0) width = 1;
        q = s / width;
        return (q >= cells) ? cells - 1 : int'(q);
    endfunction

    // Advance, reflect, bin and count one particle
    function automatic t_bounce bounce_and_bin(t_particle p);
        t_bounce r;
        longint px, py, vx, vy, mx, my, wl, wr, wt, wb;
        int rx, ry, qx, qy, idx;
        wl = wall_cfg.wall_left; wr = wall_cfg.wall_right;
        wt = wall_cfg.wall_top;  wb = wall_cfg.wall_bottom;
        px = p.pos_x; py = p.pos_y; vx = p.vel_x; vy = p.vel_y;
        px += floor_shift16(vx * 30 * longint'(p.time_step));
        py += floor_shift16(vy * 30 * longint'(p.time_step));
        for (int k = 0; k < 2; k++) begin
            if (px < wl) begin
                px = 2 * wl - px; vx = clamp16(-vx);
            end else if (px > wr) begin
                px = 2 * wr - px; vx = clamp16(-vx);
            end else if (py > wt) begin
                py = 2 * wt - py; vy = clamp16(-vy);
            end else if (py < wb) begin
                py = 2 * wb - py; vy = clamp16(-vy);
            end
        end
        px = clamp16(px); py = clamp16(py);
        mx = longint'(p.mass) * vx;
        my = longint'(p.mass) * vy;
        rx = grid_cell(px, wl, wall_cfg.pos_bw, POS_N);
        ry = grid_cell(py, wb, wall_cfg.pos_bw, POS_N);
        qx = grid_cell(mx, wl, wall_cfg.mom_bw, MOM_N);
        qy = grid_cell(my, wb, wall_cfg.mom_bw, MOM_N);
        idx = ((rx * POS_N + ry) * MOM_N + qx) * MOM_N + qy;
        if (hist_counts[idx] != 8'hFF) hist_counts[idx] = hist_counts[idx] + 8'd1;
        r.new_pos_x = px[15:0]; r.new_pos_y = py[15:0];
        r.new_vel_x = vx[15:0]; r.new_vel_y = vy[15:0];
        r.mom_x = mx[23:0]; r.mom_y = my[23:0];
        r.pos_cell_x = rx[3:0]; r.pos_cell_y = ry[3:0];
        r.mom_cell_x = qx[2:0]; r.mom_cell_y = qy[2:0];
        r.cell_count = hist_counts[idx];
        return r;
    endfunction

    // Driver: present queued items, hold each until accepted
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_ch.valid <= 1'b0;
        end else if (item_ch.valid && !item_ch.ready) begin
            // hold
        end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            item_ch.valid <= 1'b0;
        end else if (pending_particles.size() > 0) begin
            {item_ch.action, item_ch.pos_x, item_ch.pos_y, item_ch.vel_x, item_ch.vel_y,
             item_ch.mass, item_ch.time_step} <= pending_particles.pop_front();
            item_ch.valid <= 1'b1;
            if (!quiet_tail && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 18);
        end else begin
            item_ch.valid <= 1'b0;
        end
    end

    // Predict on acceptance
    always @(posedge i_clk) begin
        t_particle p;
        if (i_rst_n && item_ch.valid && item_ch.ready) begin
            p = {item_ch.action, item_ch.pos_x, item_ch.pos_y, item_ch.vel_x, item_ch.vel_y,
                 item_ch.mass, item_ch.time_step};
            if (p.action == pwb_pkg::ACT_CLEAR) begin
                foreach (hist_counts[i]) hist_counts[i] = 8'd0;
            end else begin
                expected_bounces.insert(expected_bounces.size(), bounce_and_bin(p));
            end
        end
    end

    // Result sink with random stall bursts
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            res_ch.ready <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 11) == 0) begin
            stall_left <= $urandom_range(0, 17);
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    // Monitor: compare each result with the oldest expectation
    always @(posedge i_clk) begin
        t_bounce got;
        t_bounce exp_r;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got = {res_ch.new_pos_x, res_ch.new_pos_y, res_ch.new_vel_x, res_ch.new_vel_y,
                   res_ch.mom_x, res_ch.mom_y, res_ch.pos_cell_x, res_ch.pos_cell_y,
                   res_ch.mom_cell_x, res_ch.mom_cell_y, res_ch.cell_count};
            if (expected_bounces.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                fail_count++;
            end else begin
                exp_r = expected_bounces.pop_front();
                moves_checked++;
                if (got.new_pos_x !== exp_r.new_pos_x || got.new_pos_y !== exp_r.new_pos_y ||
                    got.new_vel_x !== exp_r.new_vel_x || got.new_vel_y !== exp_r.new_vel_y ||
                    got.mom_x !== exp_r.mom_x || got.mom_y !== exp_r.mom_y ||
                    got.pos_cell_x !== exp_r.pos_cell_x || got.pos_cell_y !== exp_r.pos_cell_y ||
                    got.mom_cell_x !== exp_r.mom_cell_x || got.mom_cell_y !== exp_r.mom_cell_y ||
                    got.cell_count !== exp_r.cell_count) begin
                    $display("%0t: mismatch expected %h actual %h", $time, exp_r, got);
                    fail_count++;
                end
            end
        end
    end

    // Register write channel
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_ch.valid <= 1'b0;
            cfg_ch.idx <= pwb_pkg::CFG_WALL_LEFT;
            cfg_ch.data <= 16'd0;
        end else if (cfg_ch.valid && cfg_ch.ready) begin
            cfg_ch.valid <= 1'b0;
            pending_cfg <= 1'b0;
        end else if (pending_cfg && !cfg_ch.valid) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.idx <= pending_idx;
            cfg_ch.data <= pending_data;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        pending_idx = idx;
        pending_data = data;
        pending_cfg = 1'b1;
        wait (pending_cfg == 1'b0);
        @(posedge i_clk);
        case (idx)
            pwb_pkg::CFG_WALL_LEFT:   wall_cfg.wall_left = data;
            pwb_pkg::CFG_WALL_RIGHT:  wall_cfg.wall_right = data;
            pwb_pkg::CFG_WALL_TOP:    wall_cfg.wall_top = data;
            pwb_pkg::CFG_WALL_BOTTOM: wall_cfg.wall_bottom = data;
            pwb_pkg::CFG_POS_BW:      wall_cfg.pos_bw = data[14:0];
            pwb_pkg::CFG_MOM_BW:      wall_cfg.mom_bw = data[14:0];
            default: ;
        endcase
    endtask

    task automatic set_walls(input logic [15:0] wl, wr, wt, wb, pbw, mbw);
        write_reg(pwb_pkg::CFG_WALL_LEFT, wl);
        write_reg(pwb_pkg::CFG_WALL_RIGHT, wr);
        write_reg(pwb_pkg::CFG_WALL_TOP, wt);
        write_reg(pwb_pkg::CFG_WALL_BOTTOM, wb);
        write_reg(pwb_pkg::CFG_POS_BW, pbw);
        write_reg(pwb_pkg::CFG_MOM_BW, mbw);
    endtask

    // Wait until every item is taken and every result checked, then let clears finish
    task automatic drain();
        wait (pending_particles.size() == 0 && !item_ch.valid && expected_bounces.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_move(input logic signed [15:0] px, py, vx, vy,
                              input logic [7:0] m, input logic [15:0] dt);
        pending_particles.insert(pending_particles.size(),
                                 {pwb_pkg::ACT_MOVE, px, py, vx, vy, m, dt});
    endtask

    function automatic logic [15:0] rand_field(int mode);
        case (mode)
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom);
            default: return 16'($signed($urandom_range(0, 8000)) - 4000);
        endcase
    endfunction

    // Random phase: mostly in-box particles, with clears and wild values
    task automatic random_phase(input int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 39) == 0) begin
                pending_particles.insert(pending_particles.size(),
                                         {pwb_pkg::ACT_CLEAR, 16'($urandom), 16'($urandom),
                                          16'($urandom), 16'($urandom), 8'($urandom),
                                          16'($urandom)});
                clears_sent++;
            end else if ($urandom_range(0, 3) == 0) begin
                queue_move(rand_field($urandom_range(0, 3)), rand_field($urandom_range(0, 3)),
                           rand_field($urandom_range(0, 3)), rand_field($urandom_range(0, 3)),
                           8'($urandom), 16'($urandom));
            end else begin
                queue_move(rand_field(3), rand_field(3), rand_field(3), rand_field(3),
                           8'($urandom), 16'($urandom_range(0, 4000)));
            end
        end
    endtask

    initial begin
        wall_cfg = '{pwb_pkg::RST_WALL_LEFT, pwb_pkg::RST_WALL_RIGHT, pwb_pkg::RST_WALL_TOP,
                     pwb_pkg::RST_WALL_BOTTOM, pwb_pkg::RST_POS_BW, pwb_pkg::RST_MOM_BW};
        foreach (hist_counts[i]) hist_counts[i] = 8'd0;
        item_ch.valid = 1'b0; item_ch.action = pwb_pkg::ACT_MOVE;
        item_ch.pos_x = '0; item_ch.pos_y = '0; item_ch.vel_x = '0; item_ch.vel_y = '0;
        item_ch.mass = '0; item_ch.time_step = '0;
        res_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0; cfg_ch.idx = pwb_pkg::CFG_WALL_LEFT; cfg_ch.data = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, each wall, saturation, clear
        queue_move(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 8'd0, 16'd0);
        queue_move(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 8'hFF, 16'hFFFF);
        queue_move(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 8'hFF, 16'hFFFF);
        queue_move(-16'sd7000, 16'sd0, -16'sd2000, 16'sd0, 8'd3, 16'd4000);
        queue_move(16'sd7000, 16'sd0, 16'sd2000, 16'sd0, 8'd3, 16'd4000);
        queue_move(16'sd0, 16'sd7000, 16'sd0, 16'sd2000, 8'd3, 16'd4000);
        queue_move(16'sd0, -16'sd7000, 16'sd0, -16'sd2000, 8'd3, 16'd4000);
        queue_move(16'sd7600, 16'sd7600, 16'sd3000, 16'sd3000, 8'd9, 16'd2000);
        queue_move(16'sh8000, 16'sd0, 16'sh8000, 16'sd0, 8'd1, 16'd0);
        queue_move(16'sd100, 16'sd100, -16'sd1, -16'sd1, 8'd1, 16'd1);
        for (int i = 0; i < 8; i++) queue_move(16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'd1, 16'd0);
        pending_particles.insert(pending_particles.size(),
                                 {pwb_pkg::ACT_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                  16'hFFFF, 8'hFF, 16'hFFFF});
        clears_sent++;
        queue_move(16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'd1, 16'd0);
        drain();

        // Saturate one cell past 255
        for (int i = 0; i < 270; i++) queue_move(16'sd5, 16'sd5, 16'sd0, 16'sd0, 8'd0, 16'd0);
        random_phase(100);
        drain();

        // Tight box, narrow bins, minimum widths
        set_walls(-16'sd512, 16'sd512, 16'sd512, -16'sd512, 16'd1, 16'd1);
        random_phase(200);
        drain();

        // Extreme and crossed walls, maximum widths; zero width wraps to one LSB
        set_walls(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF);
        random_phase(120);
        drain();
        set_walls(16'sd3000, -16'sd3000, -16'sd2000, 16'sd2000, 16'h8000, 16'd0);
        random_phase(120);
        drain();

        // Back to reset setup, no idling in the tail
        set_walls(pwb_pkg::RST_WALL_LEFT, pwb_pkg::RST_WALL_RIGHT, pwb_pkg::RST_WALL_TOP,
                  pwb_pkg::RST_WALL_BOTTOM, 16'(pwb_pkg::RST_POS_BW),
                  16'(pwb_pkg::RST_MOM_BW));
        random_phase(120);
        drain();
        quiet_tail = 1'b1;
        random_phase(100);
        drain();

        $display("Checked %0d particle moves with %0d histogram clears over five wall setups.",
                 moves_checked, clears_sent);
        if (fail_count == 0) begin
            $display("tb_particle_wall_bounce_phase_histogram_top passed");
        end else begin
            $display("tb_particle_wall_bounce_phase_histogram_top failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #8000000;
        $display("tb_particle_wall_bounce_phase_histogram_top failed");
        $finish;
    end
endmodule
`default_nettype wire
